### rtl/fph_pkg.sv
// Shared constants and types of the fractal Perlin height sampler.
package fph_pkg;

	localparam int unsigned FPH_TABLE_DEPTH = 1024;
	localparam int unsigned FPH_OCTAVES     = 4;
	localparam int unsigned FPH_FRAC        = 16;
	localparam int unsigned FPH_BASE_SHIFT  = 3;
	localparam int unsigned FPH_CELL_W      = FPH_BASE_SHIFT + FPH_OCTAVES;
	localparam int unsigned FPH_HASH_W      = 13;
	localparam int unsigned FPH_OCT_W       = (FPH_OCTAVES > 1) ? $clog2(FPH_OCTAVES) : 1;
	localparam int unsigned FPH_HSHIFT      = FPH_FRAC + FPH_BASE_SHIFT + FPH_OCTAVES - 1 - 16;
	localparam logic [6:0]  FPH_HASH_MX     = 7'd41;
	localparam logic [6:0]  FPH_HASH_MY     = 7'd43;
	localparam int signed   FPH_HEIGHT_MIN  = -65536;
	localparam int signed   FPH_HEIGHT_MAX  = 65535;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CELL,
		ST_ISSUE,
		ST_DRAIN,
		ST_BLA,
		ST_BLB,
		ST_BLC,
		ST_BLD,
		ST_OUT
	} state_t;

endpackage

### rtl/fractal_perlin_height.sv
// Top level of the fractal Perlin height sampler.
//
// Usage: raise start with the item fields while busy is low; the item is
// transferred at that clock edge. opcode OP_LOAD writes one gradient table
// entry in the transfer cycle and busy stays low, so the next item may follow
// at once. opcode OP_SAMPLE raises busy; done pulses for exactly one cycle
// with height_value, and busy falls in the cycle after done.
// For each of the four octaves a sample splits the point, reads the four
// corner entries from the single-port gradient memory, finishes the corner
// dot products and runs the blend multiplies; an output state follows.
// The receiver cannot stall: done is a strobe, and height_value holds only
// until the next item is accepted. Reset clears the control state; the
// gradient table is not cleared, and every entry a sample reads must have
// been loaded since reset.
module fractal_perlin_height
	import fph_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = FPH_TABLE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [9:0]         table_index,
	input  logic signed [15:0] grad_x,
	input  logic signed [15:0] grad_y,
	input  logic [15:0]        sample_x,
	input  logic [15:0]        sample_y,
	output logic               done,
	output logic signed [16:0] height_value
);

	localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned RS    = 26;
	localparam logic [26:0] RECIP = 27'((64'd1 << RS) / TABLE_DEPTH);

	state_t state_q, state_d;

	logic [31:0] mem [TABLE_DEPTH];

	logic [15:0]           sx_q, sy_q;
	logic [FPH_OCT_W-1:0]  oct_q;
	logic [1:0]            k_q;
	logic [FPH_CELL_W-1:0] cx_q, cy_q;
	logic [15:0]           fx_q, fy_q;

	logic                  accept;
	logic [31:0]           px, py;
	logic [FPH_CELL_W-1:0] cxk, cyk;
	logic [FPH_HASH_W-1:0] hash_raw, mod_in;
	logic [39:0]           recip_prod;
	logic [31:0]           rem_a;
	logic [AW-1:0]         idx;

	logic [31:0]        rdata_s1;
	logic               vld_s1, vld_s2;
	logic [1:0]         k_s1, k_s2;
	logic signed [17:0] ox, oy;
	logic signed [33:0] prx_s2, pry_s2;
	logic signed [34:0] dot_sum;
	logic signed [20:0] d_q [4];

	logic [15:0]        t2x_q, t3x_q, t2y_q, t3y_q;
	logic [31:0]        m2x, m3x, m2y, m3y;
	logic signed [18:0] ex_q, ey_q;

	logic signed [40:0] bp1_q, bp2_q;
	logic signed [25:0] r1_q, r2_q;
	logic signed [45:0] bp3_q;
	logic signed [27:0] n_val;
	logic signed [31:0] acc_q;
	logic signed [31:0] h_val;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Split the point for the current octave
	assign px = {16'b0, sx_q} << (FPH_BASE_SHIFT + 32'(oct_q));
	assign py = {16'b0, sy_q} << (FPH_BASE_SHIFT + 32'(oct_q));

	// Corner hash; it or the load index is reduced modulo the table depth
	assign cxk      = cx_q + FPH_CELL_W'(k_q[0]);
	assign cyk      = cy_q + FPH_CELL_W'(k_q[1]);
	assign hash_raw = FPH_HASH_W'(cxk * FPH_HASH_MX) + FPH_HASH_W'(cyk * FPH_HASH_MY);
	assign mod_in   = busy ? hash_raw : FPH_HASH_W'(table_index);

	always_comb begin
		recip_prod = 40'(mod_in) * 40'(RECIP);
		rem_a = 32'(mod_in) - 32'(recip_prod[39:RS]) * 32'(TABLE_DEPTH);
		if (rem_a >= 32'(TABLE_DEPTH)) begin
			rem_a = rem_a - 32'(TABLE_DEPTH);
		end
		idx = rem_a[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == OP_LOAD) begin
			mem[idx] <= {grad_y, grad_x};
		end
		if (state_q == ST_ISSUE) begin
			rdata_s1 <= mem[idx];
		end
	end

	// Corner offsets and dot products
	assign ox = k_s1[0] ? ($signed({2'b0, fx_q}) - 18'sd65536) : $signed({2'b0, fx_q});
	assign oy = k_s1[1] ? ($signed({2'b0, fy_q}) - 18'sd65536) : $signed({2'b0, fy_q});
	assign dot_sum = 35'(prx_s2) + 35'(pry_s2);

	always_ff @(posedge clk) begin
		prx_s2 <= ox * $signed(rdata_s1[15:0]);
		pry_s2 <= oy * $signed(rdata_s1[31:16]);
		k_s2   <= k_s1;
		k_s1   <= k_q;
		if (vld_s2) begin
			d_q[k_s2] <= dot_sum[34:14];
		end
	end

	// Fade curves: square and cube terms are registered, then the blend weights
	assign m2x = fx_q * fx_q;
	assign m3x = t2x_q * fx_q;
	assign m2y = fy_q * fy_q;
	assign m3y = t2y_q * fy_q;

	always_ff @(posedge clk) begin
		t2x_q <= m2x[31:16];
		t3x_q <= m3x[31:16];
		t2y_q <= m2y[31:16];
		t3y_q <= m3y[31:16];
		ex_q  <= $signed(19'(t2x_q) * 19'd3 - 19'(t3x_q) * 19'd2);
		ey_q  <= $signed(19'(t2y_q) * 19'd3 - 19'(t3y_q) * 19'd2);
	end

	// Blend
	assign n_val = 28'(r1_q) + 28'($signed(bp3_q[45:16]));

	always_ff @(posedge clk) begin
		bp1_q <= ex_q * (22'(d_q[1]) - 22'(d_q[0]));
		bp2_q <= ex_q * (22'(d_q[3]) - 22'(d_q[2]));
		r1_q  <= 26'(d_q[0]) + $signed(bp1_q[40:16]);
		r2_q  <= 26'(d_q[2]) + $signed(bp2_q[40:16]);
		bp3_q <= ey_q * (27'(r2_q) - 27'(r1_q));
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sx_q <= sample_x;
			sy_q <= sample_y;
		end
		if (state_q == ST_CELL) begin
			cx_q <= px[16 +: FPH_CELL_W];
			cy_q <= py[16 +: FPH_CELL_W];
			fx_q <= px[15:0];
			fy_q <= py[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			oct_q   <= '0;
			k_q     <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			acc_q   <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == ST_ISSUE);
			vld_s2  <= vld_s1;
			if (accept) begin
				oct_q <= '0;
				acc_q <= '0;
			end
			if (state_q == ST_ISSUE) begin
				k_q <= k_q + 2'd1;
			end
			if (state_q == ST_BLD) begin
				acc_q <= acc_q + (32'(n_val) <<< (FPH_OCTAVES - 1 - 32'(oct_q)));
				oct_q <= oct_q + FPH_OCT_W'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OP_SAMPLE) begin
					state_d = ST_CELL;
				end
			end
			ST_CELL:  state_d = ST_ISSUE;
			ST_ISSUE: begin
				if (k_q == 2'd3) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!vld_s1 && !vld_s2) begin
					state_d = ST_BLA;
				end
			end
			ST_BLA: state_d = ST_BLB;
			ST_BLB: state_d = ST_BLC;
			ST_BLC: state_d = ST_BLD;
			ST_BLD: begin
				if (32'(oct_q) == FPH_OCTAVES - 1) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_CELL;
				end
			end
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Scale to 2^-16 units and saturate
	assign h_val = acc_q >>> FPH_HSHIFT;
	assign done  = (state_q == ST_OUT);

	always_comb begin
		if (h_val < FPH_HEIGHT_MIN) begin
			height_value = 17'(FPH_HEIGHT_MIN);
		end else if (h_val > FPH_HEIGHT_MAX) begin
			height_value = 17'(FPH_HEIGHT_MAX);
		end else begin
			height_value = h_val[16:0];
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_LOAD) |=> !busy) else $error("load raised busy");
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_SAMPLE) |=> busy) else $error("sample not taken");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without work");
	a_read_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $past(vld_s1)) else $error("read pipe out of order");

endmodule
